// ----- sv/esort_pkg.sv -----
// esort_pkg: shared types for the exchange sort engine.
// Holds the element word type and the sequencer state encoding.
// No dependencies.
package esort_pkg;

  localparam int WORD_W = 32;

  typedef logic signed [WORD_W-1:0] word_t;

  typedef enum logic [7:0] {
    S_LOAD  = 8'b0000_0001,
    S_START = 8'b0000_0010,
    S_LDI   = 8'b0000_0100,
    S_CMP   = 8'b0000_1000,
    S_WRI   = 8'b0001_0000,
    S_ERD   = 8'b0010_0000,
    S_ELD   = 8'b0100_0000,
    S_EWAIT = 8'b1000_0000
  } state_t;

endpackage

// ----- sv/exchange_sort_engine_core.sv -----
// exchange_sort_engine_core: collects a set of signed words, sorts it with an
// exchange sort held in one memory, and emits it ascending. Depends on esort_pkg, esort_store.
// The sort steps through S_START, S_LDI, S_CMP and S_WRI, one compare per cycle in each pass
// through the single memory read port; each result is then loaded in S_ELD and held in S_EWAIT.
// Throughput: one set at a time; input is stalled from the last item until the last result.
// Reset: synchronous, clears count, overflow flag, state and output valid; store is not cleared.
module exchange_sort_engine_core #(
  parameter int CAPACITY = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  esort_pkg::word_t value,
  input  logic             last,
  output logic             out_valid,
  input  logic             out_stall,
  output esort_pkg::word_t sorted_value,
  output logic             last_out,
  output logic             overflow
);
  import esort_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  state_t        state;
  logic [CW-1:0] count;
  logic          dropped;
  logic [AW-1:0] i;
  logic [AW-1:0] j;
  logic [AW-1:0] k;
  word_t         cur;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  word_t         mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  word_t         mem_rdata;

  logic [CW-1:0] i_ext;
  logic [CW-1:0] j_ext;
  logic [CW-1:0] k_ext;
  logic [CW-1:0] j_inc;
  logic [CW-1:0] i_inc;
  logic [CW-1:0] i_inc2;
  logic [CW-1:0] k_inc;
  logic [CW-1:0] count_next;
  logic          has_room;
  logic          j_more;
  logic          i_more;
  logic          swap;

  esort_store #(
    .DEPTH(CAPACITY),
    .AW   (AW)
  ) u_store (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  assign in_stall   = (state != S_LOAD);
  assign i_ext      = CW'(i);
  assign j_ext      = CW'(j);
  assign k_ext      = CW'(k);
  assign j_inc      = j_ext + CW'(1);
  assign i_inc      = i_ext + CW'(1);
  assign i_inc2     = i_ext + CW'(2);
  assign k_inc      = k_ext + CW'(1);
  assign has_room   = (count < CAP_C);
  assign count_next = has_room ? count + CW'(1) : count;
  assign j_more     = (j_inc < count);
  assign i_more     = (i_inc2 < count);
  assign swap       = (cur > mem_rdata);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = value;
    mem_re    = 1'b0;
    mem_raddr = '0;
    case (state)
      S_LOAD: begin
        if (in_valid && has_room) begin
          mem_we    = 1'b1;
          mem_waddr = count[AW-1:0];
        end
      end
      S_START: begin
        mem_re = 1'b1;
      end
      S_LDI: begin
        mem_re    = 1'b1;
        mem_raddr = j;
      end
      S_CMP: begin
        mem_we    = swap;
        mem_waddr = j;
        mem_wdata = cur;
        mem_re    = j_more;
        mem_raddr = j_inc[AW-1:0];
      end
      S_WRI: begin
        mem_we    = 1'b1;
        mem_waddr = i;
        mem_wdata = cur;
        mem_re    = i_more;
        mem_raddr = i_inc[AW-1:0];
      end
      S_ERD: begin
        mem_re    = 1'b1;
        mem_raddr = k;
      end
      S_EWAIT: begin
        mem_re    = !out_stall && !last_out;
        mem_raddr = k_inc[AW-1:0];
      end
      default: begin
        mem_re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      count     <= '0;
      dropped   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_LOAD: begin
          if (in_valid) begin
            count <= count_next;
            if (!has_room) begin
              dropped <= 1'b1;
            end
            if (last) begin
              i     <= '0;
              j     <= AW'(1);
              k     <= '0;
              state <= (count_next > CW'(1)) ? S_START : S_ERD;
            end
          end
        end
        S_START: begin
          state <= S_LDI;
        end
        S_LDI: begin
          cur   <= mem_rdata;
          state <= S_CMP;
        end
        S_CMP: begin
          if (swap) begin
            cur <= mem_rdata;
          end
          if (j_more) begin
            j <= j_inc[AW-1:0];
          end else begin
            state <= S_WRI;
          end
        end
        S_WRI: begin
          if (i_more) begin
            i     <= i_inc[AW-1:0];
            j     <= i_inc2[AW-1:0];
            state <= S_LDI;
          end else begin
            state <= S_ERD;
          end
        end
        S_ERD: begin
          state <= S_ELD;
        end
        S_ELD: begin
          out_valid    <= 1'b1;
          sorted_value <= mem_rdata;
          last_out     <= (k_inc == count);
          overflow     <= dropped;
          state        <= S_EWAIT;
        end
        S_EWAIT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            if (last_out) begin
              count   <= '0;
              dropped <= 1'b0;
              state   <= S_LOAD;
            end else begin
              k     <= k_inc[AW-1:0];
              state <= S_ELD;
            end
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CAP_C)
    else $error("element count beyond capacity");

  a_out_state: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (state == S_EWAIT))
    else $error("result valid outside emit wait");

  a_cmp_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_CMP) |-> (j > i))
    else $error("compare index not beyond anchor index");

  a_port_clash: assert property (@(posedge clk) disable iff (rst)
    (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    else $error("read and write to the same entry in one cycle");

  a_run_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && last_out) |=> (count == '0 && !dropped && state == S_LOAD))
    else $error("set state not cleared after final item");

endmodule

// ----- sv/esort_store.sv -----
// esort_store: element store, one write port and one registered read port.
// Read data is registered, appearing in the cycle after the read enable, and holds otherwise.
// Depends on esort_pkg.
module esort_store #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  esort_pkg::word_t wdata,
  input  logic            re,
  input  logic [AW-1:0]   raddr,
  output esort_pkg::word_t rdata
);
  import esort_pkg::*;

  word_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
